### rtl/core/aes128_cbc_decrypt_defines.svh
// Assertion macros for the AES-128 CBC decrypt block.
`ifndef AES128_CBC_DECRYPT_DEFINES_SVH
`define AES128_CBC_DECRYPT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

### rtl/core/aescbc_pkg.sv
package aescbc_pkg;
  localparam int KeyWords = 44;
  localparam int Rounds = 10;
  localparam logic [7:0] ReducePoly = 8'h1b;

  typedef logic [127:0] block_t;

  typedef struct packed {
    logic       load;
    logic       start;
    logic       round;
    logic       last;
    logic [3:0] rnd;
    logic [1:0] col;
  } dp_cmd_t;

  localparam logic [7:0] InvSbox [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

  function automatic logic [7:0] gf_double(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? ReducePoly : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [3:0] m);
    logic [7:0] acc;
    logic [7:0] v;
    acc = '0;
    v = x;
    for (int b = 0; b < 4; b++) begin
      if (m[b]) acc = acc ^ v;
      v = gf_double(v);
    end
    return acc;
  endfunction
endpackage

### rtl/core/aescbc_if.sv
interface aescbc_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [5:0]  key_index;
  logic [31:0] key_value;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic        chain_start;
  modport source (output valid, action, key_index, key_value, block_high, block_low,
                  chain_start, input ready);
  modport sink (input valid, action, key_index, key_value, block_high, block_low,
                chain_start, output ready);
endinterface

interface aescbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_high;
  logic [63:0] plain_low;
  modport source (output valid, plain_high, plain_low, input ready);
  modport sink (input valid, plain_high, plain_low, output ready);
endinterface

### rtl/core/aescbc_ctrl.sv
module aescbc_ctrl
  import aescbc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_action,
  input  logic    in_chain,
  input  logic    out_ready,
  output logic    in_ready,
  output logic    out_valid,
  output dp_cmd_t cmd
);
  // FETCH reads the four words of a round key, one per cycle, ROUND applies it.
  typedef enum logic [1:0] {IDLE, FETCH, ROUND, DONE} state_t;
  state_t state;
  logic [3:0] rnd;
  logic [1:0] col;
  logic       first;

  assign in_ready = (state == IDLE);
  assign out_valid = (state == DONE);

  always_comb begin
    cmd = '0;
    cmd.rnd = rnd;
    cmd.col = col;
    cmd.load = in_valid && in_ready;
    cmd.start = in_valid && in_ready && in_action && !in_chain;
    cmd.round = (state == ROUND);
    cmd.last = first;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      rnd <= '0;
      col <= '0;
      first <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (cmd.start) begin
            state <= FETCH;
            rnd <= 4'(Rounds);
            col <= '0;
            first <= 1'b1;
          end
        end
        FETCH: begin
          col <= col + 2'd1;
          if (col == 2'd3) state <= ROUND;
        end
        ROUND: begin
          first <= 1'b0;
          if (rnd == 4'd0) begin
            state <= DONE;
          end else begin
            rnd <= rnd - 4'd1;
            state <= FETCH;
          end
        end
        DONE: begin
          if (out_ready) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

### rtl/core/aescbc_dp.sv
module aescbc_dp
  import aescbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  input  logic        action,
  input  logic [5:0]  key_index,
  input  logic [31:0] key_value,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  input  logic        chain_start,
  output logic [63:0] plain_high,
  output logic [63:0] plain_low
);
  logic [31:0] key_mem [KeyWords];
  logic [31:0] key_rd;
  logic [127:0] rkey;
  logic [127:0] st;
  logic [127:0] cur;
  logic [127:0] prev;
  logic [127:0] sub;
  logic [127:0] addk;
  logic [127:0] mixed;
  logic [127:0] st_next;
  logic [5:0]   rd_addr;
  logic         rd_pend;
  logic [1:0]   rd_col;

  assign rd_addr = {cmd.rnd, cmd.col};

  // Key table: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.load && !action && key_index < 6'(KeyWords)) key_mem[key_index] <= key_value;
    key_rd <= key_mem[rd_addr[5:0] < 6'(KeyWords) ? rd_addr : 6'd0];
  end

  // Read data is registered; the FETCH state precedes each round cycle,
  // so the fourth word lands while the round is being applied.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      rd_col <= '0;
    end else begin
      rd_pend <= !cmd.round && !cmd.load;
      rd_col <= cmd.col;
    end
    if (rd_pend) rkey[127 - 32*rd_col -: 32] <= key_rd;
  end

  // Word 3 of the key is in flight during the round cycle; bypass it.
  always_comb begin
    cur = rkey;
    cur[31:0] = key_rd;
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        sub[127 - 8*(r + 4*c) -: 8] = InvSbox[st[127 - 8*(r + 4*((c + 4 - r) % 4)) -: 8]];
      end
    end
    addk = (cmd.last ? st : sub) ^ cur;
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3;
      a0 = addk[127 - 32*c -: 8];
      a1 = addk[119 - 32*c -: 8];
      a2 = addk[111 - 32*c -: 8];
      a3 = addk[103 - 32*c -: 8];
      mixed[127 - 32*c -: 8] = gf_mul(a0, 4'd14) ^ gf_mul(a1, 4'd11) ^ gf_mul(a2, 4'd13)
                              ^ gf_mul(a3, 4'd9);
      mixed[119 - 32*c -: 8] = gf_mul(a0, 4'd9) ^ gf_mul(a1, 4'd14) ^ gf_mul(a2, 4'd11)
                              ^ gf_mul(a3, 4'd13);
      mixed[111 - 32*c -: 8] = gf_mul(a0, 4'd13) ^ gf_mul(a1, 4'd9) ^ gf_mul(a2, 4'd14)
                              ^ gf_mul(a3, 4'd11);
      mixed[103 - 32*c -: 8] = gf_mul(a0, 4'd11) ^ gf_mul(a1, 4'd13) ^ gf_mul(a2, 4'd9)
                              ^ gf_mul(a3, 4'd14);
    end
    st_next = (cmd.last || cmd.rnd == 4'd0) ? addk : mixed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= '0;
    end else if (cmd.load && action) begin
      prev <= {block_high, block_low};
    end
    if (cmd.start) st <= {block_high, block_low};
    else if (cmd.round) st <= st_next;
  end

  // Chaining XOR happens on the final round using the block accepted before this item;
  // prev already holds the current ciphertext, so keep the older one aside.
  logic [127:0] chain;
  always_ff @(posedge clk) begin
    if (rst) chain <= '0;
    else if (cmd.start) chain <= prev;
    else if (cmd.load && action && chain_start) chain <= {block_high, block_low};
  end

  always_ff @(posedge clk) begin
    if (cmd.round && cmd.rnd == 4'd0 && !cmd.last) begin
      plain_high <= st_next[127:64] ^ chain[127:64];
      plain_low <= st_next[63:0] ^ chain[63:0];
    end
  end
endmodule

### rtl/core/aes128_cbc_decrypt.sv
// AES-128 CBC decryption block.
// Channel in_ch carries load items (action 0, one expanded key word each)
// and block items (action 1). A block with chain_start set becomes the IV.
// Channel out_ch returns one plaintext item for each other block item.
// Loads and IV items leave the block idle and ready. For a ciphertext block,
// from acceptance to a valid result, for each of the eleven round keys the
// single read port of the key table fetches its four words in FETCH, then
// one round is applied in ROUND. The next item is accepted only once the
// result has been taken, so blocks are not overlapped.
// Reset (synchronous, active high) clears the chaining block to zero and
// returns the controller to idle; the key table must be loaded again.
// When the receiver stalls, the result is held steady on out_ch and no
// new item is accepted until it has been taken.
module aes128_cbc_decrypt
  import aescbc_pkg::*;
(
  input logic clk,
  input logic rst,
  aescbc_in_if.sink    in_ch,
  aescbc_out_if.source out_ch
);
  dp_cmd_t cmd;

  aescbc_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_action(in_ch.action), .in_chain(in_ch.chain_start),
    .out_ready(out_ch.ready), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
    .cmd(cmd)
  );

  aescbc_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .action(in_ch.action), .key_index(in_ch.key_index), .key_value(in_ch.key_value),
    .block_high(in_ch.block_high), .block_low(in_ch.block_low),
    .chain_start(in_ch.chain_start),
    .plain_high(out_ch.plain_high), .plain_low(out_ch.plain_low)
  );
endmodule

### rtl/core/aescbc_chk.sv
`include "aes128_cbc_decrypt_defines.svh"
module aescbc_chk (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  // A block is in flight whenever a result waits: no new item then.
  `ASSERT_IMPL(a_busy, clk, rst, out_valid, !in_ready, "input accepted while result waits")
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
  `ASSERT_NEXT(a_back, clk, rst, out_valid && out_ready, in_ready, "not idle after result")
  // An accepted item never yields a result on the very next cycle.
  `ASSERT_NEXT(a_quick, clk, rst, in_valid && in_ready, !out_valid, "result too early")
endmodule

bind aes128_cbc_decrypt aescbc_chk u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);
